/* src/atfd_pkg.sv */
// ----------------------------------------------------------------------------
// AT frame deframer package
// Field widths, character codes and buffer positions shared by the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package atfd_pkg;

   // Field widths of the item on each channel.
   localparam int BYTE_W      = 8;
   localparam int ID_W        = 32;
   localparam int LEN_W       = 4;
   localparam int PAYLOAD_W   = 64;
   localparam int PAY_IDX_W   = 3;

   // Largest payload a frame may carry.
   localparam int MAX_DATA_DEFAULT = 8;

   // Frame overhead: header (2), identifier (4), length (1), trailer (2).
   localparam int FRAME_OVERHEAD = 9;

   // Byte positions within a frame, counted from the header 'A'.
   localparam int IDX_ID_FIRST = 2;
   localparam int IDX_ID_LAST  = 5;
   localparam int IDX_LEN      = 6;
   localparam int IDX_DATA     = 7;
   localparam int IDX_TRAILER  = 8;

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CH_T  = 8'h54;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

endpackage : atfd_pkg

`default_nettype wire

/* src/atfd_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module atfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : atfd_ram

`default_nettype wire

/* src/at_frame_deframer.sv */
// ----------------------------------------------------------------------------
// AT frame deframer
// Hunts for 'A','T' headers in a byte stream and returns complete frames.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes arrive one item at a time on the req_ channel. Every byte is
//   appended to a small circular stream memory. A sequencer reads the memory
//   one byte at a time and feeds a single byte parser, which collects the
//   identifier, length and payload of a frame and checks the CR LF trailer.
//   A good frame gives one item on the rsp_ channel. A bad trailer or an
//   oversized length rewinds the read pointer to the byte after the header,
//   so those bytes are parsed again.
//   Timing: each parsed byte takes a memory read (ST_READ), then a parse
//   (ST_PROC); a byte that causes no rewind returns the block to ready after its parse;
//   a finished frame is shown on rsp_ the cycle after its last byte is
//   parsed. A rewind replays up to 7 + MAX_DATA bytes, and replayed bytes may
//   rewind again, each time from a header at least two bytes later, so one
//   item sees at most (8 + MAX_DATA) / 2 rewinds. req_ready is high only while
//   the parser has no byte left to read.
//   Reset clears the pointers, the parser state and the output valid; the
//   stream memory itself is not cleared and needs no clearing pass.
//   While the receiver stalls with a result held, bytes are still parsed;
//   only a second finished frame waits until the held item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module at_frame_deframer #(
   parameter int MAX_DATA = atfd_pkg::MAX_DATA_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [atfd_pkg::BYTE_W-1:0]    req_rx_byte,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [atfd_pkg::ID_W-1:0]      rsp_frame_id,
   output      logic [atfd_pkg::LEN_W-1:0]     rsp_data_length,
   output      logic [atfd_pkg::PAYLOAD_W-1:0] rsp_payload
);

   // Longest frame in bytes, and the widths that follow from it.
   localparam int FRAME_MAX    = atfd_pkg::FRAME_OVERHEAD + MAX_DATA;
   localparam int FILL_W       = $clog2(FRAME_MAX + 1);
   localparam int PTR_W        = FILL_W;
   localparam int STREAM_DEPTH = 1 << PTR_W;

   localparam int BYTE_W    = atfd_pkg::BYTE_W;
   localparam int ID_W      = atfd_pkg::ID_W;
   localparam int LEN_W     = atfd_pkg::LEN_W;
   localparam int PAYLOAD_W = atfd_pkg::PAYLOAD_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_PROC = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]     hdr_next_ff, hdr_next_in;
   logic                 gather_ff, gather_in;
   logic                 held_ff, held_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [BYTE_W-1:0]    prev_ff, prev_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;

   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [BYTE_W-1:0]    cur_byte;

   logic                 restart;
   logic                 complete;
   logic                 stall;
   logic [PTR_W-1:0]     rd_next;
   logic [FILL_W-1:0]    len_ext;
   logic [FILL_W-1:0]    data_off;
   logic [PTR_W-1:0]     frame_span;

   // Stream memory holding recent received bytes for replay.
   atfd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STREAM_DEPTH)
   ) u_stream_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (cur_byte)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign len_ext   = FILL_W'(len_ff);
   assign data_off  = fill_ff - FILL_W'(atfd_pkg::IDX_DATA);

   // Byte parser: decides what the current byte does to the frame state.
   always_comb begin
      restart     = 1'b0;
      complete    = 1'b0;
      gather_in   = gather_ff;
      held_in     = held_ff;
      fill_in     = fill_ff;
      hdr_next_in = hdr_next_ff;
      prev_in     = cur_byte;
      id_in       = id_ff;
      len_in      = len_ff;
      payload_in  = payload_ff;

      if (!gather_ff) begin
         // Hunting: a held 'A' followed by 'T' opens a frame.
         if (held_ff && (cur_byte == atfd_pkg::CH_T)) begin
            gather_in   = 1'b1;
            held_in     = 1'b0;
            fill_in     = FILL_W'(2);
            hdr_next_in = rd_ptr_ff + PTR_W'(1);
         end else if (cur_byte == atfd_pkg::CH_A) begin
            held_in = 1'b1;
         end else begin
            held_in = 1'b0;
         end
      end else begin
         fill_in = fill_ff + FILL_W'(1);
         if ((fill_ff >= FILL_W'(atfd_pkg::IDX_ID_FIRST)) &&
             (fill_ff <= FILL_W'(atfd_pkg::IDX_ID_LAST))) begin
            id_in = {id_ff[ID_W-BYTE_W-1:0], cur_byte};
         end
         if (fill_ff == FILL_W'(atfd_pkg::IDX_LEN)) begin
            len_in     = cur_byte[LEN_W-1:0];
            payload_in = '0;
            if (cur_byte > BYTE_W'(MAX_DATA)) begin
               restart = 1'b1;
            end
         end
         if ((fill_ff >= FILL_W'(atfd_pkg::IDX_DATA)) &&
             (fill_ff < FILL_W'(atfd_pkg::IDX_DATA) + len_ext)) begin
            payload_in[BYTE_W * data_off[atfd_pkg::PAY_IDX_W-1:0] +: BYTE_W] = cur_byte;
         end
         // The last byte of the frame settles it on the trailer.
         if (fill_ff == FILL_W'(atfd_pkg::IDX_TRAILER) + len_ext) begin
            if ((prev_ff == atfd_pkg::CH_CR) && (cur_byte == atfd_pkg::CH_LF)) begin
               complete = 1'b1;
            end else begin
               restart = 1'b1;
            end
         end
         if (restart || complete) begin
            gather_in = 1'b0;
            held_in   = 1'b0;
         end
      end
   end

   assign stall   = complete && rsp_valid_ff && !rsp_ready;
   assign rd_next = restart ? hdr_next_ff : (rd_ptr_ff + PTR_W'(1));

   // Sequencer: accept a byte, then read and parse until the stream is drained.
   always_comb begin
      state_in  = state_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ram_wr_en = 1'b1;
               wr_ptr_in = wr_ptr_ff + PTR_W'(1);
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_PROC;
         end
         ST_PROC: begin
            if (!stall) begin
               rd_ptr_in = rd_next;
               state_in  = (rd_next == wr_ptr_ff) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loads a finished frame, clears when the item is taken.
   always_comb begin
      rsp_id_in      = rsp_id_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if ((state_ff == ST_PROC) && complete && !stall) begin
         rsp_valid_in   = 1'b1;
         rsp_id_in      = id_ff;
         rsp_len_in     = len_ff;
         rsp_payload_in = payload_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         gather_ff    <= 1'b0;
         held_ff      <= 1'b0;
         fill_ff      <= '0;
         hdr_next_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if ((state_ff == ST_PROC) && !stall) begin
            gather_ff   <= gather_in;
            held_ff     <= held_in;
            fill_ff     <= fill_in;
            hdr_next_ff <= hdr_next_in;
         end
      end
   end

   // Frame contents and output payload.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_PROC) && !stall) begin
         prev_ff    <= prev_in;
         id_ff      <= id_in;
         len_ff     <= len_in;
         payload_ff <= payload_in;
      end
      rsp_id_ff      <= rsp_id_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_id    = rsp_id_ff;
   assign rsp_data_length = rsp_len_ff;
   assign rsp_payload     = rsp_payload_ff;

   assign frame_span = wr_ptr_ff - hdr_next_ff;

   // The block only takes a byte once every stored byte has been parsed.
   a_ready_drained : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("input taken while bytes remain to be parsed");

   // An accepted item always leads to at least one read before the next.
   a_accept_reads : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_READ))
      else $error("accepted item was not read back");

   // A frame being gathered never outgrows the longest legal frame.
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      gather_ff |-> (fill_ff < FILL_W'(FRAME_MAX)))
      else $error("frame fill beyond the longest frame");

   // The bytes of an open frame are still in the stream memory.
   a_span_bound : assert property (@(posedge clock) disable iff (reset)
      gather_ff |-> (frame_span <= PTR_W'(FRAME_MAX - 2)))
      else $error("open frame overwritten in the stream memory");

   // A reported frame never carries more than the largest payload.
   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_len_ff <= LEN_W'(MAX_DATA)))
      else $error("reported length above the largest payload");

endmodule : at_frame_deframer

`default_nettype wire
